### sv/rational_arith_unit_top_macros.svh
// Assertion helpers used by the RTL sequencer (rau_ctrl).
`ifndef RATIONAL_ARITH_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITH_UNIT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Types, codes and helpers of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int IN_W  = 32;
    localparam int RES_W = 64;
    localparam int CNT_W = 7;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_DIV = 2'd2;

    typedef struct packed {
        logic [1:0]             req_type;
        logic signed [IN_W-1:0] a_num;
        logic signed [IN_W-1:0] a_den;
        logic signed [IN_W-1:0] b_num;
        logic signed [IN_W-1:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [RES_W-1:0] res_num;
        logic signed [RES_W-1:0] res_den;
        logic                    zero_den_error;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_SUM,
        S_GCD_INIT,
        S_GCD_TEST,
        S_GCD_WAIT,
        S_QN_WAIT,
        S_QD_WAIT,
        S_FIN
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_ZERO,
        DP_SHARED,
        DP_ANBD_ACC,
        DP_BNAD_RN,
        DP_ADBD_RD,
        DP_ANBN_RN,
        DP_ANBD_RN,
        DP_ADBN_RD,
        DP_SUM,
        DP_GCD_INIT,
        DP_GCD_START,
        DP_GCD_STEP,
        DP_QN_START,
        DP_QN_DONE,
        DP_QD_DONE,
        DP_OUT
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       ad_eq_bd;
        logic       x_zero;
        logic       y_zero;
        logic       div_done;
        logic       out_free;
    } t_status;

    function automatic logic [RES_W-1:0] magnitude(input logic [RES_W-1:0] v);
        return v[RES_W-1] ? (RES_W'(0) - v) : v;
    endfunction

endpackage

### sv/rau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rau_pkg::RES_W-1:0]  i_dividend,
    input  logic [rau_pkg::RES_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [rau_pkg::RES_W-1:0]  o_quo,
    output logic [rau_pkg::RES_W-1:0]  o_rem
);
    localparam int W = rau_pkg::RES_W;

    logic [W-1:0]                  r_quo;
    logic [W-1:0]                  r_rem;
    logic [W-1:0]                  r_dvs;
    logic [rau_pkg::CNT_W-1:0]     r_cnt;
    logic                          r_done;
    logic [W:0]                    shifted;
    logic [W:0]                    diff;

    assign shifted = {r_rem, r_quo[W-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= rau_pkg::CNT_W'(W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == rau_pkg::CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            // keep the partial remainder when the trial subtract goes negative
            r_rem <= diff[W] ? shifted[W-1:0] : diff[W-1:0];
            r_quo <= {r_quo[W-2:0], ~diff[W]};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

### sv/rau_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand registers, shared multiplier, gcd registers, divider
// and output register.
// ----------------------------------------------------------------------------
module rau_dp #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rau_pkg::t_dp_cmd  i_cmd,
    input  rau_pkg::t_in      i_in,
    output rau_pkg::t_status  o_status,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output rau_pkg::t_out     o_out
);
    localparam int W  = OPERAND_WIDTH;
    localparam int RW = rau_pkg::RES_W;

    logic [1:0]              r_op;
    logic signed [W-1:0]     r_an, r_ad, r_bn, r_bd;
    logic signed [RW-1:0]    r_acc, r_rn, r_rd;
    logic [RW-1:0]           r_x, r_y;
    rau_pkg::t_out           r_out;
    logic                    r_out_valid;

    logic signed [W-1:0]     mul_a, mul_b;
    logic signed [2*W-1:0]   prod;
    logic signed [RW-1:0]    prod64;
    logic                    div_start;
    logic [RW-1:0]           div_dvd, div_dvs;
    logic                    div_done;
    logic [RW-1:0]           div_quo, div_rem;

    always_comb begin
        unique case (i_cmd)
            rau_pkg::DP_ANBD_ACC, rau_pkg::DP_ANBD_RN: begin
                mul_a = r_an; mul_b = r_bd;
            end
            rau_pkg::DP_BNAD_RN: begin
                mul_a = r_bn; mul_b = r_ad;
            end
            rau_pkg::DP_ADBD_RD: begin
                mul_a = r_ad; mul_b = r_bd;
            end
            rau_pkg::DP_ADBN_RD: begin
                mul_a = r_ad; mul_b = r_bn;
            end
            default: begin
                mul_a = r_an; mul_b = r_bn;
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod64 = RW'(prod);

    always_comb begin
        div_start = 1'b0;
        div_dvd   = r_x;
        div_dvs   = r_y;
        unique case (i_cmd)
            rau_pkg::DP_GCD_START: begin
                div_start = 1'b1;
            end
            rau_pkg::DP_QN_START: begin
                div_start = 1'b1;
                div_dvd   = rau_pkg::magnitude(r_rn);
                div_dvs   = r_x;
            end
            rau_pkg::DP_QN_DONE: begin
                div_start = 1'b1;
                div_dvd   = rau_pkg::magnitude(r_rd);
                div_dvs   = r_x;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            rau_pkg::DP_LOAD: begin
                r_op <= i_in.req_type;
                r_an <= i_in.a_num[W-1:0];
                r_ad <= i_in.a_den[W-1:0];
                r_bn <= i_in.b_num[W-1:0];
                r_bd <= i_in.b_den[W-1:0];
            end
            rau_pkg::DP_ZERO: begin
                r_rn <= '0;
                r_rd <= '0;
            end
            rau_pkg::DP_SHARED: begin
                r_rn <= RW'(r_an) + RW'(r_bn);
                r_rd <= RW'(r_ad);
            end
            rau_pkg::DP_ANBD_ACC: r_acc <= prod64;
            rau_pkg::DP_BNAD_RN, rau_pkg::DP_ANBN_RN, rau_pkg::DP_ANBD_RN: r_rn <= prod64;
            rau_pkg::DP_ADBD_RD, rau_pkg::DP_ADBN_RD: r_rd <= prod64;
            rau_pkg::DP_SUM: r_rn <= r_rn + r_acc;
            rau_pkg::DP_GCD_INIT: begin
                r_x <= rau_pkg::magnitude(r_rn);
                r_y <= rau_pkg::magnitude(r_rd);
            end
            rau_pkg::DP_GCD_STEP: begin
                r_x <= r_y;
                r_y <= div_rem;
            end
            rau_pkg::DP_QN_DONE: r_rn <= r_rn[RW-1] ? -$signed(div_quo) : $signed(div_quo);
            rau_pkg::DP_QD_DONE: r_rd <= r_rd[RW-1] ? -$signed(div_quo) : $signed(div_quo);
            rau_pkg::DP_OUT: begin
                r_out.res_num        <= r_rn;
                r_out.res_den        <= r_rd;
                r_out.zero_den_error <= (r_rd == '0);
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == rau_pkg::DP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.op       = r_op;
    assign o_status.ad_eq_bd = (r_ad == r_bd);
    assign o_status.x_zero   = (r_x == '0);
    assign o_status.y_zero   = (r_y == '0);
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

### sv/rau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: steps the datapath through products, sum and gcd reduction.
// ----------------------------------------------------------------------------
`include "rational_arith_unit_top_macros.svh"

module rau_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rau_pkg::t_status  i_status,
    output rau_pkg::t_dp_cmd  o_cmd
);
    rau_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = rau_pkg::DP_NOP;
        unique case (r_state)
            rau_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = rau_pkg::DP_LOAD;
                    n_state = rau_pkg::S_MUL_A;
                end
            end
            rau_pkg::S_MUL_A: begin
                priority if (i_status.op == rau_pkg::OP_ADD) begin
                    if (i_status.ad_eq_bd) begin
                        o_cmd   = rau_pkg::DP_SHARED;
                        n_state = rau_pkg::S_GCD_INIT;
                    end else begin
                        o_cmd   = rau_pkg::DP_ANBD_ACC;
                        n_state = rau_pkg::S_MUL_B;
                    end
                end else if (i_status.op == rau_pkg::OP_MUL) begin
                    o_cmd   = rau_pkg::DP_ANBN_RN;
                    n_state = rau_pkg::S_MUL_B;
                end else if (i_status.op == rau_pkg::OP_DIV) begin
                    o_cmd   = rau_pkg::DP_ANBD_RN;
                    n_state = rau_pkg::S_MUL_B;
                end else begin
                    o_cmd   = rau_pkg::DP_ZERO;
                    n_state = rau_pkg::S_FIN;
                end
            end
            rau_pkg::S_MUL_B: begin
                priority if (i_status.op == rau_pkg::OP_ADD) begin
                    o_cmd   = rau_pkg::DP_BNAD_RN;
                    n_state = rau_pkg::S_MUL_C;
                end else if (i_status.op == rau_pkg::OP_MUL) begin
                    o_cmd   = rau_pkg::DP_ADBD_RD;
                    n_state = rau_pkg::S_FIN;
                end else begin
                    o_cmd   = rau_pkg::DP_ADBN_RD;
                    n_state = rau_pkg::S_FIN;
                end
            end
            rau_pkg::S_MUL_C: begin
                o_cmd   = rau_pkg::DP_ADBD_RD;
                n_state = rau_pkg::S_SUM;
            end
            rau_pkg::S_SUM: begin
                o_cmd   = rau_pkg::DP_SUM;
                n_state = rau_pkg::S_GCD_INIT;
            end
            rau_pkg::S_GCD_INIT: begin
                o_cmd   = rau_pkg::DP_GCD_INIT;
                n_state = rau_pkg::S_GCD_TEST;
            end
            rau_pkg::S_GCD_TEST: begin
                // gcd of zero and zero: leave the sum unreduced
                priority if (!i_status.y_zero) begin
                    o_cmd   = rau_pkg::DP_GCD_START;
                    n_state = rau_pkg::S_GCD_WAIT;
                end else if (i_status.x_zero) begin
                    n_state = rau_pkg::S_FIN;
                end else begin
                    o_cmd   = rau_pkg::DP_QN_START;
                    n_state = rau_pkg::S_QN_WAIT;
                end
            end
            rau_pkg::S_GCD_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd   = rau_pkg::DP_GCD_STEP;
                    n_state = rau_pkg::S_GCD_TEST;
                end
            end
            rau_pkg::S_QN_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd   = rau_pkg::DP_QN_DONE;
                    n_state = rau_pkg::S_QD_WAIT;
                end
            end
            rau_pkg::S_QD_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd   = rau_pkg::DP_QD_DONE;
                    n_state = rau_pkg::S_FIN;
                end
            end
            rau_pkg::S_FIN: begin
                // hold the result until the output register is free
                if (i_status.out_free) begin
                    o_cmd   = rau_pkg::DP_OUT;
                    n_state = rau_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rau_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != rau_pkg::S_IDLE);

    `RAU_ASSERT_NEXT(a_load_starts, i_clk, i_rst_n, (i_in_valid && !o_in_stall), (r_state == rau_pkg::S_MUL_A))
    `RAU_ASSERT_NEXT(a_gcd_waits, i_clk, i_rst_n, (r_state == rau_pkg::S_GCD_TEST && !i_status.y_zero), (r_state == rau_pkg::S_GCD_WAIT))
    `RAU_ASSERT_NEXT(a_fin_drains, i_clk, i_rst_n, (r_state == rau_pkg::S_FIN && i_status.out_free), (r_state == rau_pkg::S_IDLE))
endmodule

### sv/rational_arith_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit_top
// Two-fraction arithmetic unit: add with gcd reduction, multiply, divide.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries one request (operation and
// two fractions); output channel o_out_valid / i_out_stall returns one result
// with numerator, denominator and a zero-denominator flag.
// One request is worked on at a time. Multiply and divide load the request,
// form both products and present their result, then take the next request
// from the idle state; any other operation code returns 0/0 with the
// zero-denominator flag set. An add forms the sum in one step with equal
// denominators and in three products and a sum step otherwise, then reduces
// it. The reduction runs Euclid's algorithm on a shared 64-bit restoring
// divider: each remainder step starts the divider, waits for done and steps
// the gcd registers, and two closing divisions divide numerator and
// denominator by the gcd; the divider sets the rate.
// The next request is taken once the result sits in the output register,
// even if the receiver has not yet taken it. If the receiver stalls and a
// second result is ready, the sequencer holds it until the register frees.
// Reset clears the sequencer and the output valid; no request is in flight.
// ----------------------------------------------------------------------------
module rational_arith_unit_top #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rau_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rau_pkg::t_out  o_out_data
);
    rau_pkg::t_dp_cmd cmd;
    rau_pkg::t_status status;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rau_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in_data),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );
endmodule

### dv/tb_rational_arith_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arith_unit_top
// Checks the two-fraction arithmetic unit against a behavioural predictor.
// Directed corner fractions, then random add/multiply/divide and undefined-op
// requests with random idling on both channels, then a back-to-back run;
// results are compared in order.
module tb_rational_arith_unit_top;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_stall;
    rau_pkg::t_in   i_in_data = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    rau_pkg::t_out  o_out_data;

    rau_pkg::t_out  pending_fractions[$];
    int    error_count = 0;
    int    idle_cycles = 0;
    bit    allow_idling = 1'b1;
    int    stall_left = 0;

    rational_arith_unit_top dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] div_keep_sign(input logic [63:0] v, input logic [63:0] g);
        logic [63:0] q;
        q = abs64(v) / g;
        return v[63] ? (64'd0 - q) : q;
    endfunction

    function automatic rau_pkg::t_out fraction_result(input rau_pkg::t_in req);
        rau_pkg::t_out r;
        logic [63:0] an, ad, bn, bd, x, y, t;
        an = 64'(req.a_num);
        ad = 64'(req.a_den);
        bn = 64'(req.b_num);
        bd = 64'(req.b_den);
        case (req.req_type)
            rau_pkg::OP_ADD: begin
                if (ad == bd) begin
                    r.res_num = an + bn;
                    r.res_den = ad;
                end else begin
                    r.res_num = an * bd + bn * ad;
                    r.res_den = ad * bd;
                end
                x = abs64(r.res_num);
                y = abs64(r.res_den);
                while (y != 0) begin
                    t = x % y;
                    x = y;
                    y = t;
                end
                if (x != 0) begin
                    r.res_num = div_keep_sign(r.res_num, x);
                    r.res_den = div_keep_sign(r.res_den, x);
                end
            end
            rau_pkg::OP_MUL: begin
                r.res_num = an * bn;
                r.res_den = ad * bd;
            end
            rau_pkg::OP_DIV: begin
                r.res_num = an * bd;
                r.res_den = ad * bn;
            end
            default: begin
                r.res_num = '0;
                r.res_den = '0;
            end
        endcase
        r.zero_den_error = (r.res_den == 0);
        return r;
    endfunction

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (!allow_idling) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // check each result transaction
    always @(posedge i_clk) begin
        rau_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_fractions.size() == 0) begin
                $error("unexpected result num=%0d den=%0d", o_out_data.res_num,
                       o_out_data.res_den);
                error_count++;
            end else begin
                want = pending_fractions.pop_front();
                if (o_out_data.res_num !== want.res_num) begin
                    $error("res_num expected %0d actual %0d", want.res_num,
                           o_out_data.res_num);
                    error_count++;
                end
                if (o_out_data.res_den !== want.res_den) begin
                    $error("res_den expected %0d actual %0d", want.res_den,
                           o_out_data.res_den);
                    error_count++;
                end
                if (o_out_data.zero_den_error !== want.zero_den_error) begin
                    $error("zero_den_error expected %0b actual %0b",
                           want.zero_den_error, o_out_data.zero_den_error);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // valid stays high after a transaction until the next one or an idle gap
    task automatic send_fractions(input logic [1:0] op, input logic [31:0] an,
                                  input logic [31:0] ad, input logic [31:0] bn,
                                  input logic [31:0] bd);
        rau_pkg::t_in req;
        int gap;
        req = '{req_type: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
        if (allow_idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (o_in_stall);
        pending_fractions.push_back(fraction_result(req));
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 4))
            0: return 32'($signed($urandom_range(0, 20)) - 10);
            1: return 32'($urandom_range(0, 1000)) * 32'($urandom_range(1, 12));
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000001;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_fractions(rau_pkg::OP_ADD, 1, 2, 1, 3);
        send_fractions(rau_pkg::OP_ADD, 1, 4, 1, 4);
        send_fractions(rau_pkg::OP_ADD, 3, 0, 5, 7);
        send_fractions(rau_pkg::OP_ADD, 0, 6, 0, 9);
        send_fractions(rau_pkg::OP_ADD, 0, 0, 0, 0);
        send_fractions(rau_pkg::OP_ADD, -1, 2, 1, -2);
        send_fractions(rau_pkg::OP_ADD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h80000001);
        send_fractions(rau_pkg::OP_ADD, 32'h80000000, 1, 32'h80000000, 1);
        send_fractions(rau_pkg::OP_ADD, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000);
        send_fractions(rau_pkg::OP_MUL, 32'h7fffffff, 32'h80000001, 32'h80000001,
                       32'h7fffffff);
        send_fractions(rau_pkg::OP_MUL, 2, 0, 3, 5);
        send_fractions(rau_pkg::OP_MUL, -3, 4, 5, -6);
        send_fractions(rau_pkg::OP_DIV, 1, 2, 0, 3);
        send_fractions(rau_pkg::OP_DIV, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000);
        send_fractions(rau_pkg::OP_DIV, -7, 9, 3, -11);
        send_fractions(OP_NONE, 5, 6, 7, 8);
        send_fractions(OP_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    endtask

    task automatic test_random(input int count);
        logic [31:0] ad;
        for (int n = 0; n < count; n++) begin
            ad = rand_operand();
            send_fractions($urandom_range(0, 15) == 0 ? OP_NONE : 2'($urandom_range(0, 2)),
                           rand_operand(), ad, rand_operand(),
                           $urandom_range(0, 3) == 0 ? ad : rand_operand());
        end
    endtask

    task automatic test_back_to_back(input int count);
        allow_idling = 1'b0;
        test_random(count);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1450);
        test_back_to_back(200);
        i_in_valid <= 1'b0;
        while (pending_fractions.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
